// ===== hw/rtl/interleaved_bank_burst_splitter_defines.svh =====
// Assertion macros shared by the burst splitter RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef INTERLEAVED_BANK_BURST_SPLITTER_DEFINES_SVH
`define INTERLEAVED_BANK_BURST_SPLITTER_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define IBBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("burst splitter same-cycle check failed");

// Check that a condition implies another in the next cycle
`define IBBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("burst splitter next-cycle check failed");

`endif

// ===== hw/rtl/ibbs_pkg.sv =====
// Types and constants for the bank-interleaved burst splitter.
// Depends on nothing; used by every RTL module of the block.
package ibbs_pkg;

  // Fixed field widths
  localparam int ADDR_WIDTH     = 32;
  localparam int SIZE_WIDTH     = 16;
  localparam int MAX_BANKS      = 64;
  localparam int GRAN_MAX       = 12;
  localparam int COUNT_WIDTH    = 7;
  localparam int SEL_WIDTH      = 3;
  localparam int GRAN_WIDTH     = 4;
  localparam int CHUNK_WIDTH    = 13;
  localparam int BIDX_WIDTH     = 6;
  localparam int OPC_WIDTH      = 6;
  localparam int INIT_WIDTH     = 8;
  localparam int LAT_WIDTH      = 16;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 32;

  // Configuration register indexes
  typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BANK_COUNT       = 2'd0;
  localparam cfg_idx_t CFG_BANK_SELECT_BITS = 2'd1;
  localparam cfg_idx_t CFG_INTERLEAVE_BITS  = 2'd2;
  localparam cfg_idx_t CFG_ADDRESS_MASK     = 2'd3;

  // Field codes
  localparam logic REQ_START      = 1'b0;
  localparam logic REQ_RESPONSE   = 1'b1;
  localparam logic RESULT_CHUNK   = 1'b0;
  localparam logic RESULT_DONE    = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [ADDR_WIDTH-1:0] address;
    logic [SIZE_WIDTH-1:0] byte_count;
    logic                  write_flag;
    logic [OPC_WIDTH-1:0]  access_opcode;
    logic [INIT_WIDTH-1:0] initiator_id;
    logic                  bank_ok;
    logic [LAT_WIDTH-1:0]  bank_latency;
  } in_item_t;

  typedef struct packed {
    logic                   result_kind;
    logic [BIDX_WIDTH-1:0]  bank_index;
    logic [ADDR_WIDTH-1:0]  bank_address;
    logic [CHUNK_WIDTH-1:0] chunk_bytes;
    logic [SIZE_WIDTH-1:0]  data_offset;
    logic                   chunk_write;
    logic [OPC_WIDTH-1:0]   chunk_opcode;
    logic [INIT_WIDTH-1:0]  chunk_initiator;
    logic                   done_status;
    logic [LAT_WIDTH-1:0]   done_latency;
  } out_item_t;

  // Classified item as held in the queue
  typedef enum logic [1:0] {
    KIND_START,
    KIND_RESP_OK,
    KIND_RESP_ERR
  } item_kind_t;

  typedef struct packed {
    item_kind_t            kind;
    logic                  empty_burst;
    logic [ADDR_WIDTH-1:0] address;
    logic [SIZE_WIDTH-1:0] byte_count;
    logic                  write_flag;
    logic [OPC_WIDTH-1:0]  opcode;
    logic [INIT_WIDTH-1:0] initiator;
    logic [LAT_WIDTH-1:0]  latency;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

// ===== hw/rtl/interleaved_bank_burst_splitter.sv =====
// Top level of the bank-interleaved burst splitter: front, queue, back.
// Depends on ibbs_pkg, ibbs_front, ibbs_queue and ibbs_back.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   in      | input     | in_valid / in_stall    | in_data (ibbs_pkg::in_item_t)
//   out     | output    | out_valid / out_stall  | out_data (ibbs_pkg::out_item_t)
//   cfg     | input     | cfg_write              | cfg_index, cfg_data
//
// Sustains one input item per cycle while the queue is not full; an accepted item is
// first written into a queue slot, then the back-end step registers its result into
// the output register.
// The rate is set by the back end's combinational step: chunk advance plus bank remap.
// Reset is synchronous on rst; there is no clearing pass.
// in_stall rises only when the queue of QUEUE_DEPTH items is full; out_stall holds
// the output register and, once the queue fills, backs up into in_stall.
module interleaved_bank_burst_splitter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ibbs_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ibbs_pkg::out_item_t                 out_data,
  input  logic                                cfg_write,
  input  ibbs_pkg::cfg_idx_t                  cfg_index,
  input  logic [ibbs_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
  import ibbs_pkg::*;

  q_push_t   q_push;
  q_status_t q_status;
  q_entry_t  q_data;
  logic      q_pop;

  // Accept and classify
  ibbs_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push)
  );

  // Decouple front and back
  ibbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_push   (q_push),
    .pop      (q_pop),
    .q_status (q_status),
    .q_data   (q_data)
  );

  // Split bursts and report completions
  ibbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_status.valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/ibbs_front.sv =====
// Front end: accepts input items and classifies them for the queue.
// Depends on ibbs_pkg.
module ibbs_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  ibbs_pkg::in_item_t in_data,
  input  ibbs_pkg::q_status_t q_status,
  output ibbs_pkg::q_push_t  q_push
);
  import ibbs_pkg::*;

  // Stall only while the queue has no free slot
  assign in_stall = q_status.full;

  // Classify the item: burst start, good response or failed response
  always_comb begin
    q_push.push              = in_valid && !q_status.full;
    q_push.entry.kind        = (in_data.req_type == REQ_START) ? KIND_START :
                               (in_data.bank_ok ? KIND_RESP_OK : KIND_RESP_ERR);
    q_push.entry.empty_burst = (in_data.byte_count == '0);
    q_push.entry.address     = in_data.address;
    q_push.entry.byte_count  = in_data.byte_count;
    q_push.entry.write_flag  = in_data.write_flag;
    q_push.entry.opcode      = in_data.access_opcode;
    q_push.entry.initiator   = in_data.initiator_id;
    q_push.entry.latency     = in_data.bank_latency;
  end

endmodule

// ===== hw/rtl/ibbs_queue.sv =====
// Short FIFO of classified items between front and back end.
// Depends on ibbs_pkg.
module ibbs_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  ibbs_pkg::q_push_t   q_push,
  input  logic                pop,
  output ibbs_pkg::q_status_t q_status,
  output ibbs_pkg::q_entry_t  q_data
);
  import ibbs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign do_push        = q_push.push && !q_status.full;
  assign do_pop         = pop && q_status.valid;
  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.valid = (count != '0);
  assign q_data         = entries[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_push.entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ibbs_back.sv =====
// Back end: configuration registers, burst state and chunk/completion output.
// Depends on ibbs_pkg and the shared assertion macros.
`include "interleaved_bank_burst_splitter_defines.svh"

module ibbs_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  ibbs_pkg::cfg_idx_t                  cfg_index,
  input  logic [ibbs_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
  input  logic                                q_valid,
  input  ibbs_pkg::q_entry_t                  q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ibbs_pkg::out_item_t                 out_data
);
  import ibbs_pkg::*;

  // floor(log2(v)), zero for zero
  function automatic logic [SEL_WIDTH-1:0] count_log2(input logic [COUNT_WIDTH-1:0] v);
    logic [SEL_WIDTH-1:0] r;
    r = '0;
    for (int b = 1; b < COUNT_WIDTH; b++) begin
      if (v >= (COUNT_WIDTH'(1) << b)) begin
        r = SEL_WIDTH'(b);
      end
    end
    return r;
  endfunction

  // Configuration registers
  logic [COUNT_WIDTH-1:0]    bank_count;
  logic [SEL_WIDTH-1:0]      bank_select_bits;
  logic [GRAN_WIDTH-1:0]     interleave_bits;
  logic [ADDR_WIDTH-1:0]     address_mask;

  // Burst state
  logic                      busy, busy_next;
  logic [ADDR_WIDTH-1:0]     next_address, next_address_next;
  logic [SIZE_WIDTH-1:0]     bytes_left, bytes_left_next;
  logic [SIZE_WIDTH-1:0]     bytes_done, bytes_done_next;
  logic [LAT_WIDTH-1:0]      worst_latency, worst_latency_next;
  logic                      held_write, held_write_next;
  logic [OPC_WIDTH-1:0]      held_opcode, held_opcode_next;
  logic [INIT_WIDTH-1:0]     held_initiator, held_initiator_next;
  logic [CHUNK_WIDTH-1:0]    cur_len, cur_len_next;
  logic                      out_valid_next;
  out_item_t                 out_data_next;

  // Derived configuration
  logic [COUNT_WIDTH-1:0]    eff_count;
  logic [SEL_WIDTH-1:0]      sel_bits;
  logic [GRAN_WIDTH-1:0]     gran_bits;
  logic [ADDR_WIDTH-1:0]     eff_mask;
  logic [ADDR_WIDTH-1:0]     low_mask;
  logic [COUNT_WIDTH-1:0]    sel_mask;
  logic [CHUNK_WIDTH-1:0]    gran_size;
  logic [4:0]                remap_shift;

  // Step datapath
  logic                      take;
  logic                      is_start;
  logic [ADDR_WIDTH-1:0]     upd_addr;
  logic [SIZE_WIDTH-1:0]     upd_left;
  logic [SIZE_WIDTH-1:0]     upd_done;
  logic [LAT_WIDTH-1:0]      upd_worst;
  logic [ADDR_WIDTH-1:0]     src_addr;
  logic [SIZE_WIDTH-1:0]     src_left;
  logic [SIZE_WIDTH-1:0]     src_done;
  logic                      src_write;
  logic [OPC_WIDTH-1:0]      src_opcode;
  logic [INIT_WIDTH-1:0]     src_initiator;
  logic [COUNT_WIDTH-1:0]    iss_bank;
  logic [ADDR_WIDTH-1:0]     iss_masked;
  logic [ADDR_WIDTH-1:0]     iss_local;
  logic [CHUNK_WIDTH-1:0]    iss_room;
  logic [CHUNK_WIDTH-1:0]    iss_len;
  logic                      do_issue;
  logic                      emit;
  out_item_t                 result;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_count       <= COUNT_WIDTH'(1);
      bank_select_bits <= '0;
      interleave_bits  <= '0;
      address_mask     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BANK_COUNT:       bank_count       <= cfg_data[COUNT_WIDTH-1:0];
        CFG_BANK_SELECT_BITS: bank_select_bits <= cfg_data[SEL_WIDTH-1:0];
        CFG_INTERLEAVE_BITS:  interleave_bits  <= cfg_data[GRAN_WIDTH-1:0];
        CFG_ADDRESS_MASK:     address_mask     <= cfg_data[ADDR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Resolve defaults and clamps of the configuration
  always_comb begin
    eff_count   = (bank_count > COUNT_WIDTH'(MAX_BANKS)) ? COUNT_WIDTH'(MAX_BANKS) : bank_count;
    sel_bits    = (bank_select_bits != '0) ? bank_select_bits : count_log2(eff_count);
    gran_bits   = (interleave_bits > GRAN_WIDTH'(GRAN_MAX)) ? GRAN_WIDTH'(GRAN_MAX)
                                                             : interleave_bits;
    eff_mask    = (address_mask != '0) ? address_mask : '1;
    low_mask    = (ADDR_WIDTH'(1) << gran_bits) - ADDR_WIDTH'(1);
    sel_mask    = (COUNT_WIDTH'(1) << sel_bits) - COUNT_WIDTH'(1);
    gran_size   = CHUNK_WIDTH'(1) << gran_bits;
    remap_shift = 5'(sel_bits) + 5'(gran_bits);
  end

  // Take the queue head whenever the output slot is free or drains
  assign take     = q_valid && (!out_valid || !out_stall);
  assign q_pop    = take;
  assign is_start = (q_data.kind == KIND_START);

  // Advance past the chunk that the bank just answered
  always_comb begin
    upd_addr  = next_address + ADDR_WIDTH'(cur_len);
    upd_left  = bytes_left - SIZE_WIDTH'(cur_len);
    upd_done  = bytes_done + SIZE_WIDTH'(cur_len);
    upd_worst = (q_data.latency > worst_latency) ? q_data.latency : worst_latency;
  end

  // Select the state that the next chunk is cut from
  always_comb begin
    src_addr      = is_start ? q_data.address    : upd_addr;
    src_left      = is_start ? q_data.byte_count : upd_left;
    src_done      = is_start ? '0                : upd_done;
    src_write     = is_start ? q_data.write_flag : held_write;
    src_opcode    = is_start ? q_data.opcode     : held_opcode;
    src_initiator = is_start ? q_data.initiator  : held_initiator;
  end

  // Bank decode, bank-local remap and chunk length
  always_comb begin
    iss_bank   = COUNT_WIDTH'(src_addr >> gran_bits) & sel_mask;
    iss_masked = src_addr & eff_mask;
    iss_local  = ((iss_masked >> remap_shift) << gran_bits) | (iss_masked & low_mask);
    iss_room   = gran_size - (src_addr[CHUNK_WIDTH-1:0] & low_mask[CHUNK_WIDTH-1:0]);
    iss_len    = (SIZE_WIDTH'(iss_room) < src_left) ? iss_room : src_left[CHUNK_WIDTH-1:0];
  end

  // Step the burst state and form the result
  always_comb begin
    busy_next           = busy;
    next_address_next   = next_address;
    bytes_left_next     = bytes_left;
    bytes_done_next     = bytes_done;
    worst_latency_next  = worst_latency;
    held_write_next     = held_write;
    held_opcode_next    = held_opcode;
    held_initiator_next = held_initiator;
    cur_len_next        = cur_len;
    out_valid_next      = out_valid && out_stall;
    out_data_next       = out_data;
    result              = '0;
    emit                = 1'b0;
    do_issue            = 1'b0;

    if (take) begin
      case (q_data.kind)
        KIND_START: begin
          busy_next           = 1'b1;
          next_address_next   = src_addr;
          bytes_left_next     = src_left;
          bytes_done_next     = src_done;
          worst_latency_next  = '0;
          held_write_next     = src_write;
          held_opcode_next    = src_opcode;
          held_initiator_next = src_initiator;
          if (q_data.empty_burst) begin
            busy_next          = 1'b0;
            emit               = 1'b1;
            result.result_kind = RESULT_DONE;
            result.done_status = STATUS_OK;
          end else begin
            do_issue = 1'b1;
          end
        end
        KIND_RESP_OK: begin
          if (busy) begin
            next_address_next  = upd_addr;
            bytes_left_next    = upd_left;
            bytes_done_next    = upd_done;
            worst_latency_next = upd_worst;
            if (upd_left == '0) begin
              busy_next           = 1'b0;
              emit                = 1'b1;
              result.result_kind  = RESULT_DONE;
              result.done_status  = STATUS_OK;
              result.done_latency = upd_worst;
            end else begin
              do_issue = 1'b1;
            end
          end
        end
        KIND_RESP_ERR: begin
          if (busy) begin
            busy_next          = 1'b0;
            emit               = 1'b1;
            result.result_kind = RESULT_DONE;
            result.done_status = STATUS_INVALID;
          end
        end
        default: ;
      endcase

      // Issue the next chunk, or fail the burst on a missing bank
      if (do_issue) begin
        emit = 1'b1;
        if (iss_bank >= eff_count) begin
          busy_next          = 1'b0;
          result.result_kind = RESULT_DONE;
          result.done_status = STATUS_INVALID;
        end else begin
          cur_len_next           = iss_len;
          result.result_kind     = RESULT_CHUNK;
          result.bank_index      = iss_bank[BIDX_WIDTH-1:0];
          result.bank_address    = iss_local;
          result.chunk_bytes     = iss_len;
          result.data_offset     = src_done;
          result.chunk_write     = src_write;
          result.chunk_opcode    = src_opcode;
          result.chunk_initiator = src_initiator;
        end
      end

      out_valid_next = emit;
      if (emit) begin
        out_data_next = result;
      end
    end
  end

  // Hold burst state and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      out_valid <= out_valid_next;
    end
    next_address   <= next_address_next;
    bytes_left     <= bytes_left_next;
    bytes_done     <= bytes_done_next;
    worst_latency  <= worst_latency_next;
    held_write     <= held_write_next;
    held_opcode    <= held_opcode_next;
    held_initiator <= held_initiator_next;
    cur_len        <= cur_len_next;
    out_data       <= out_data_next;
  end

  // A burst start always produces a result
  `IBBS_ASSERT_NEXT(a_start_gives_result, take && is_start, out_valid)
  // A response with no burst in flight is dropped
  `IBBS_ASSERT_NEXT(a_idle_resp_dropped, take && !is_start && !busy, !out_valid)
  // A pending chunk request means a burst is in flight
  `IBBS_ASSERT_NOW(a_chunk_while_busy, out_valid && out_data.result_kind == RESULT_CHUNK, busy)
  // Chunks are nonempty and fit in one granule
  `IBBS_ASSERT_NOW(a_chunk_len,
                   out_valid && out_data.result_kind == RESULT_CHUNK,
                   out_data.chunk_bytes != '0 && out_data.chunk_bytes <= gran_size)

endmodule

// ===== bench/interleaved_bank_burst_splitter_tb.sv =====
// Self-checking bench for the bank-interleaved burst splitter: directed table plus
// random bursts, each result checked against its table entry or an in-bench chunking predictor.
// Depends on ibbs_pkg and interleaved_bank_burst_splitter.
module interleaved_bank_burst_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ibbs_pkg::*;

  localparam int ITEMS        = 2000;
  localparam int PHASES       = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int STUCK_LIMIT  = 2000;
  localparam int IDLE_PCT     = 37;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_TYPED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    in_item_t                  item;
    out_item_t                 result;
    cfg_idx_t                  reg_idx;
    logic [CFG_DATA_WIDTH-1:0] reg_val;
  } plan_row_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  in_item_t                  in_data;
  logic                      out_valid;
  logic                      out_stall;
  out_item_t                 out_data;
  logic                      cfg_write;
  cfg_idx_t                  cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  // Register copy, at reset values
  logic [COUNT_WIDTH-1:0] n_banks  = 7'd1;
  logic [SEL_WIDTH-1:0]   sel_cfg  = '0;
  logic [GRAN_WIDTH-1:0]  ilv_cfg  = '0;
  logic [ADDR_WIDTH-1:0]  mask_cfg = '0;

  // Burst state copy
  bit                    burst_busy = 1'b0;
  logic [ADDR_WIDTH-1:0] cur_addr   = '0;
  logic [SIZE_WIDTH-1:0] left_bytes = '0;
  logic [SIZE_WIDTH-1:0] done_bytes = '0;
  logic [LAT_WIDTH-1:0]  max_lat    = '0;
  logic                  hold_wr    = 1'b0;
  logic [OPC_WIDTH-1:0]  hold_opc   = '0;
  logic [INIT_WIDTH-1:0] hold_init  = '0;

  out_item_t   awaited_results[$];
  plan_row_t   plan[$];
  bit          typed_valid = 1'b0;
  out_item_t   typed_result;
  bit          gaps_on = 1'b1;
  int unsigned items_in = 0;
  int unsigned results_caused = 0;
  int unsigned errors = 0;
  int unsigned stuck_cycles = 0;
  int unsigned chunks_seen = 0;
  int unsigned done_ok = 0;
  int unsigned done_bad = 0;
  int unsigned settings = 0;

  interleaved_bank_burst_splitter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned granule_log2();
    return (ilv_cfg > GRAN_MAX) ? GRAN_MAX : int'(ilv_cfg);
  endfunction

  function automatic int unsigned usable_banks();
    return (n_banks > MAX_BANKS) ? MAX_BANKS : int'(n_banks);
  endfunction

  // Explicit select width, or floor log2 of the usable bank count
  function automatic int unsigned select_width();
    int unsigned b;
    b = 0;
    if (sel_cfg != 0) return int'(sel_cfg);
    while ((2 << b) <= usable_banks()) b++;
    return b;
  endfunction

  // Bytes up to the next granule boundary, capped by what is left
  function automatic logic [63:0] chunk_len();
    logic [63:0] g;
    logic [63:0] c;
    g = 64'd1 << granule_log2();
    c = g - ({32'd0, cur_addr} & (g - 64'd1));
    return (c < left_bytes) ? c : {48'd0, left_bytes};
  endfunction

  function automatic out_item_t finish_burst(logic status, logic [LAT_WIDTH-1:0] lat);
    out_item_t r;
    r = '0;
    r.result_kind  = RESULT_DONE;
    r.done_status  = status;
    r.done_latency = lat;
    burst_busy     = 1'b0;
    return r;
  endfunction

  // Route the chunk at cur_addr, or end the burst on an unconnected bank
  task automatic issue_chunk(output out_item_t r);
    int unsigned ib;
    int unsigned sb;
    logic [63:0] bank;
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] loc;
    logic [63:0] len;
    ib   = granule_log2();
    sb   = select_width();
    bank = ({32'd0, cur_addr} >> ib) & ((64'd1 << sb) - 64'd1);
    m    = (mask_cfg != 0) ? {32'd0, mask_cfg} : '1;
    a    = {32'd0, cur_addr} & m;
    if (bank >= usable_banks()) begin
      r = finish_burst(STATUS_INVALID, '0);
      return;
    end
    loc = ((a >> (sb + ib)) << ib) + (a & ((64'd1 << ib) - 64'd1));
    len = chunk_len();
    r = '0;
    r.result_kind     = RESULT_CHUNK;
    r.bank_index      = bank[BIDX_WIDTH-1:0];
    r.bank_address    = loc[ADDR_WIDTH-1:0];
    r.chunk_bytes     = len[CHUNK_WIDTH-1:0];
    r.data_offset     = done_bytes;
    r.chunk_write     = hold_wr;
    r.chunk_opcode    = hold_opc;
    r.chunk_initiator = hold_init;
  endtask

  task automatic split_step(input in_item_t it, output bit has, output out_item_t r);
    logic [63:0] c;
    has = 1'b1;
    r   = '0;
    if (it.req_type == REQ_START) begin
      cur_addr   = it.address;
      left_bytes = it.byte_count;
      done_bytes = '0;
      max_lat    = '0;
      hold_wr    = it.write_flag;
      hold_opc   = it.access_opcode;
      hold_init  = it.initiator_id;
      burst_busy = 1'b1;
      if (left_bytes == 0) r = finish_burst(STATUS_OK, '0);
      else issue_chunk(r);
    end else if (!burst_busy) begin
      has = 1'b0;
    end else if (!it.bank_ok) begin
      r = finish_burst(STATUS_INVALID, '0);
    end else begin
      c = chunk_len();
      if (it.bank_latency > max_lat) max_lat = it.bank_latency;
      cur_addr   = cur_addr + c[ADDR_WIDTH-1:0];
      left_bytes = left_bytes - c[SIZE_WIDTH-1:0];
      done_bytes = done_bytes + c[SIZE_WIDTH-1:0];
      if (left_bytes == 0) r = finish_burst(STATUS_OK, max_lat);
      else issue_chunk(r);
    end
  endtask

  // ---------------------------------------------------------------- checking

  function automatic bit same_result(out_item_t e, out_item_t g);
    bit ok;
    ok = 1'b1;
    if (e.result_kind !== g.result_kind) begin
      $error("result_kind: expected %0h, got %0h", e.result_kind, g.result_kind);
      ok = 1'b0;
    end
    if (e.bank_index !== g.bank_index) begin
      $error("bank_index: expected %0h, got %0h", e.bank_index, g.bank_index);
      ok = 1'b0;
    end
    if (e.bank_address !== g.bank_address) begin
      $error("bank_address: expected %0h, got %0h", e.bank_address, g.bank_address);
      ok = 1'b0;
    end
    if (e.chunk_bytes !== g.chunk_bytes) begin
      $error("chunk_bytes: expected %0h, got %0h", e.chunk_bytes, g.chunk_bytes);
      ok = 1'b0;
    end
    if (e.data_offset !== g.data_offset) begin
      $error("data_offset: expected %0h, got %0h", e.data_offset, g.data_offset);
      ok = 1'b0;
    end
    if (e.chunk_write !== g.chunk_write) begin
      $error("chunk_write: expected %0h, got %0h", e.chunk_write, g.chunk_write);
      ok = 1'b0;
    end
    if (e.chunk_opcode !== g.chunk_opcode) begin
      $error("chunk_opcode: expected %0h, got %0h", e.chunk_opcode, g.chunk_opcode);
      ok = 1'b0;
    end
    if (e.chunk_initiator !== g.chunk_initiator) begin
      $error("chunk_initiator: expected %0h, got %0h", e.chunk_initiator,
             g.chunk_initiator);
      ok = 1'b0;
    end
    if (e.done_status !== g.done_status) begin
      $error("done_status: expected %0h, got %0h", e.done_status, g.done_status);
      ok = 1'b0;
    end
    if (e.done_latency !== g.done_latency) begin
      $error("done_latency: expected %0h, got %0h", e.done_latency, g.done_latency);
      ok = 1'b0;
    end
    return ok;
  endfunction

  // Predict on each input transfer, compare on each output transfer
  always @(posedge clk) begin
    bit        has;
    bit        moved;
    out_item_t r;
    out_item_t e;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        items_in++;
        split_step(in_data, has, r);
        if (has) begin
          results_caused++;
          awaited_results.push_back(typed_valid ? typed_result : r);
        end
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (out_data.result_kind == RESULT_CHUNK) chunks_seen++;
        else if (out_data.done_status == STATUS_OK) done_ok++;
        else done_bad++;
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing expected: %0h", out_data);
          errors++;
        end else begin
          e = awaited_results.pop_front();
          if (!same_result(e, out_data)) errors++;
        end
      end
    end
    stuck_cycles = (moved || rst || cfg_write) ? 0 : stuck_cycles + 1;
  end

  // Give up when no transfer happens for too long
  always @(negedge clk) begin
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: %0d results still expected", awaited_results.size());
      $display("interleaved_bank_burst_splitter: mismatch");
      $finish;
    end
  end

  // Result side backpressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = gaps_on && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic in_item_t mk_start(logic [ADDR_WIDTH-1:0] addr,
                                        logic [SIZE_WIDTH-1:0] count, logic wr,
                                        logic [OPC_WIDTH-1:0] opc,
                                        logic [INIT_WIDTH-1:0] init);
    in_item_t it;
    it.req_type      = REQ_START;
    it.address       = addr;
    it.byte_count    = count;
    it.write_flag    = wr;
    it.access_opcode = opc;
    it.initiator_id  = init;
    it.bank_ok       = 1'($urandom);
    it.bank_latency  = LAT_WIDTH'($urandom);
    return it;
  endfunction

  // Response with junk in the burst fields
  function automatic in_item_t mk_resp(logic ok, logic [LAT_WIDTH-1:0] lat);
    in_item_t it;
    it.req_type      = REQ_RESPONSE;
    it.address       = ADDR_WIDTH'($urandom);
    it.byte_count    = SIZE_WIDTH'($urandom);
    it.write_flag    = 1'($urandom);
    it.access_opcode = OPC_WIDTH'($urandom);
    it.initiator_id  = INIT_WIDTH'($urandom);
    it.bank_ok       = ok;
    it.bank_latency  = lat;
    return it;
  endfunction

  function automatic out_item_t mk_done(logic status, logic [LAT_WIDTH-1:0] lat);
    out_item_t r;
    r = '0;
    r.result_kind  = RESULT_DONE;
    r.done_status  = status;
    r.done_latency = lat;
    return r;
  endfunction

  function automatic plan_row_t row_item(in_item_t it);
    plan_row_t p;
    p = '0;
    p.kind = ROW_ITEM;
    p.item = it;
    return p;
  endfunction

  function automatic plan_row_t row_typed(in_item_t it, out_item_t r);
    plan_row_t p;
    p = '0;
    p.kind   = ROW_TYPED;
    p.item   = it;
    p.result = r;
    return p;
  endfunction

  function automatic plan_row_t row_cfg(cfg_idx_t idx, logic [CFG_DATA_WIDTH-1:0] v);
    plan_row_t p;
    p = '0;
    p.kind    = ROW_CFG;
    p.reg_idx = idx;
    p.reg_val = v;
    return p;
  endfunction

  // Hold one input transfer until it is taken, with random gaps ahead of it
  task automatic send_item(input in_item_t it);
    int unsigned seen;
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    seen     = items_in;
    do @(negedge clk); while (items_in == seen);
  endtask

  // Drop valid, drain all expected results, then let the pipeline empty
  task automatic settle();
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_WIDTH-1:0] v);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_BANK_COUNT:       n_banks  = v[COUNT_WIDTH-1:0];
      CFG_BANK_SELECT_BITS: sel_cfg  = v[SEL_WIDTH-1:0];
      CFG_INTERLEAVE_BITS:  ilv_cfg  = v[GRAN_WIDTH-1:0];
      CFG_ADDRESS_MASK:     mask_cfg = v;
      default: ;
    endcase
    settings++;
  endtask

  // One start followed by responses, with the odd error, abandon or stray response
  task automatic run_burst();
    logic [SIZE_WIDTH-1:0] len;
    logic [ADDR_WIDTH-1:0] addr;
    int unsigned           n;
    int unsigned           cap;
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = SIZE_WIDTH'($urandom);
      2:       len = 16'hFFFF;
      default: len = SIZE_WIDTH'($urandom_range(1, 3 << granule_log2()));
    endcase
    addr = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 8192) : $urandom;
    send_item(mk_start(addr, len, 1'($urandom), OPC_WIDTH'($urandom),
                       INIT_WIDTH'($urandom)));
    cap = $urandom_range(1, 40);
    n   = 0;
    while (burst_busy && n < cap) begin
      send_item(mk_resp($urandom_range(0, 19) != 0, LAT_WIDTH'($urandom)));
      n++;
    end
    if ($urandom_range(0, 9) == 0) send_item(mk_resp(1'($urandom), LAT_WIDTH'($urandom)));
  endtask

  initial begin
    plan_row_t              p;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [SEL_WIDTH-1:0]   sel;
    logic [GRAN_WIDTH-1:0]  ilv;
    logic [ADDR_WIDTH-1:0]  msk;
    int unsigned            goal;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_BANK_COUNT;
    cfg_data  = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed part, starting from the reset register values
    plan.push_back(row_typed(mk_start('0, '0, 1'b0, '0, '0), mk_done(STATUS_OK, '0)));
    plan.push_back(row_typed(mk_start(32'hFFFF_FFFF, 16'd1, 1'b1, 6'h3F, 8'hFF),
                             '{RESULT_CHUNK, 6'd0, 32'hFFFF_FFFF, 13'd1, 16'd0, 1'b1,
                               6'h3F, 8'hFF, STATUS_OK, 16'd0}));
    plan.push_back(row_typed(mk_resp(1'b1, 16'hFFFF), mk_done(STATUS_OK, 16'hFFFF)));
    plan.push_back(row_item(mk_resp(1'b1, 16'h1234)));
    plan.push_back(row_item(mk_start('0, 16'd3, 1'b0, '0, '0)));
    plan.push_back(row_item(mk_resp(1'b1, 16'd5)));
    plan.push_back(row_item(mk_start(32'h10, 16'd2, 1'b1, 6'h15, 8'hA5)));
    plan.push_back(row_typed(mk_resp(1'b0, 16'hFFFF), mk_done(STATUS_INVALID, '0)));
    plan.push_back(row_cfg(CFG_BANK_COUNT, 32'd0));
    plan.push_back(row_typed(mk_start(32'h1234, 16'd16, 1'b0, 6'h2A, 8'h5A),
                             mk_done(STATUS_INVALID, '0)));
    plan.push_back(row_cfg(CFG_BANK_COUNT, 32'd127));
    plan.push_back(row_cfg(CFG_INTERLEAVE_BITS, 32'd15));
    plan.push_back(row_cfg(CFG_ADDRESS_MASK, 32'h0000_FFFF));
    plan.push_back(row_item(mk_start(32'hFFFF_FF00, 16'hFFFF, 1'b0, 6'h2A, 8'h3C)));
    plan.push_back(row_item(mk_resp(1'b1, 16'd100)));
    plan.push_back(row_item(mk_resp(1'b1, 16'd7)));
    plan.push_back(row_typed(mk_resp(1'b0, '0), mk_done(STATUS_INVALID, '0)));
    plan.push_back(row_cfg(CFG_BANK_SELECT_BITS, 32'd7));
    plan.push_back(row_typed(mk_start(32'h0007_F000, 16'd8, 1'b1, 6'h01, 8'h80),
                             mk_done(STATUS_INVALID, '0)));
    plan.push_back(row_cfg(CFG_BANK_SELECT_BITS, 32'd1));
    plan.push_back(row_cfg(CFG_INTERLEAVE_BITS, 32'd0));
    plan.push_back(row_cfg(CFG_ADDRESS_MASK, 32'hFFFF_FFFF));
    plan.push_back(row_cfg(CFG_BANK_COUNT, 32'd2));
    plan.push_back(row_item(mk_start(32'h7, 16'd4096, 1'b1, 6'h01, 8'h01)));
    plan.push_back(row_item(mk_resp(1'b1, '0)));
    plan.push_back(row_item(mk_resp(1'b1, 16'hFFFF)));
    plan.push_back(row_typed(mk_resp(1'b0, 16'd1), mk_done(STATUS_INVALID, '0)));

    foreach (plan[i]) begin
      p = plan[i];
      case (p.kind)
        ROW_CFG: begin
          settle();
          write_reg(p.reg_idx, p.reg_val);
        end
        ROW_TYPED: begin
          typed_valid  = 1'b1;
          typed_result = p.result;
          send_item(p.item);
        end
        default: begin
          typed_valid = 1'b0;
          send_item(p.item);
        end
      endcase
    end
    typed_valid = 1'b0;

    // Random part: one register setting per phase, extremes first
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          cnt = 7'd64;  sel = 3'd0; ilv = 4'd0;  msk = '0;
        end
        1: begin
          cnt = 7'd127; sel = 3'd7; ilv = 4'd15; msk = 32'hFFFF_FFFF;
        end
        2: begin
          cnt = 7'd0;   sel = 3'd6; ilv = 4'd12; msk = '0;
        end
        default: begin
          cnt = COUNT_WIDTH'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 127)
                                                         : 1 << $urandom_range(0, 6));
          sel = ($urandom_range(0, 1) != 0) ? 3'd0 : 3'($urandom);
          ilv = GRAN_WIDTH'($urandom);
          msk = ($urandom_range(0, 2) == 0) ? '0 : $urandom;
        end
      endcase
      // Upper data bits carry junk the block must ignore
      write_reg(CFG_BANK_COUNT, ($urandom & ~32'h7F) | cnt);
      write_reg(CFG_BANK_SELECT_BITS, ($urandom & ~32'h7) | sel);
      write_reg(CFG_INTERLEAVE_BITS, ($urandom & ~32'hF) | ilv);
      write_reg(CFG_ADDRESS_MASK, msk);
      gaps_on = (phase != 3);
      goal    = items_in + ITEMS / PHASES;
      while (items_in < goal) run_burst();
      // Close an open burst before the registers change
      if (burst_busy) send_item(mk_resp(1'b0, LAT_WIDTH'($urandom)));
    end
    gaps_on = 1'b1;
    settle();

    $display("covered %0d input transfers over %0d register writes", items_in, settings);
    $display("checked %0d chunk requests, %0d ok and %0d invalid completions",
             chunks_seen, done_ok, done_bad);
    if (errors == 0) begin
      $display("interleaved_bank_burst_splitter: match");
    end else begin
      $display("interleaved_bank_burst_splitter: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ibbs_pkg.sv
hw/rtl/ibbs_front.sv
hw/rtl/ibbs_queue.sv
hw/rtl/ibbs_back.sv
hw/rtl/interleaved_bank_burst_splitter.sv
bench/interleaved_bank_burst_splitter_tb.sv
